### rtl/ivl_pkg.sv
package ivl_pkg;

  localparam logic [31:0] IVL_SMALL_MASK  = 32'hFFFF_F800;
  localparam logic [31:0] IVL_MEDIUM_MASK = 32'hFFE0_0000;
  localparam int          IVL_MED_SHIFT   = 8;
  localparam int          IVL_LARGE_SHIFT = 18;

  localparam int IVL_OP_XY_W    = 14;
  localparam int IVL_OP_Z_W     = 24;
  localparam int IVL_ROOT_W     = 16;
  localparam int IVL_REM_W      = 19;
  localparam int IVL_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REGIME_SMALL  = 2'd0,
    REGIME_MEDIUM = 2'd1,
    REGIME_LARGE  = 2'd2
  } regime_t;

  typedef struct packed {
    regime_t                regime;
    logic [IVL_OP_XY_W-1:0] op_x;
    logic [IVL_OP_XY_W-1:0] op_y;
    logic [IVL_OP_Z_W-1:0]  op_z;
  } ivl_entry_t;

  typedef struct packed {
    logic [IVL_REM_W-1:0]  rem;
    logic [IVL_ROOT_W-1:0] root;
  } sq_acc_t;

  function automatic sq_acc_t sqrt_step(sq_acc_t a, logic [1:0] pair);
    logic [IVL_REM_W-1:0] cur;
    logic [IVL_REM_W-1:0] trial;
    sq_acc_t              r;
    cur   = {a.rem[IVL_REM_W-3:0], pair};
    trial = {1'b0, a.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {a.root[IVL_ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {a.root[IVL_ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/int_vector3_length.sv
// Approximate length of a signed 32-bit 3D vector: floor square root of the
// sum of squares of the component magnitudes, taken at one of three scales
// picked by the largest magnitude bits (z keeps the medium scale in the large
// regime), all arithmetic wrapping modulo 2^32. One word is accepted per cycle
// while the queue is not full and one result leaves per cycle while out_stall
// is low; words pass the square and sum stages and the 16-stage root pipeline
// that yields one root bit per stage. A stall on the output freezes the back
// pipeline; the input queue of QUEUE_DEPTH words raises in_stall when full.
module int_vector3_length
  import ivl_pkg::*;
#(
  parameter int QUEUE_DEPTH = IVL_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_comp_x,
  input  logic [31:0] in_comp_y,
  input  logic [31:0] in_comp_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_length
);

  logic       q_full, q_empty, q_push, q_pop;
  ivl_entry_t q_wdata, q_rdata;

  ivl_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_comp_x (in_comp_x),
    .in_comp_y (in_comp_y),
    .in_comp_z (in_comp_z),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ivl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ivl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_length (out_length)
  );

endmodule

### rtl/ivl_front.sv
module ivl_front
  import ivl_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_comp_x,
  input  logic [31:0] in_comp_y,
  input  logic [31:0] in_comp_z,
  input  logic        q_full,
  output logic        q_push,
  output ivl_entry_t  q_wdata
);

  logic [31:0] ax, ay, az, m;
  logic [31:0] mx, my, mz, lx, ly, lz;

  assign ax = in_comp_x[31] ? (32'd0 - in_comp_x) : in_comp_x;
  assign ay = in_comp_y[31] ? (32'd0 - in_comp_y) : in_comp_y;
  assign az = in_comp_z[31] ? (32'd0 - in_comp_z) : in_comp_z;
  assign m  = ax | ay | az;

  assign mx = ax >> IVL_MED_SHIFT;
  assign my = ay >> IVL_MED_SHIFT;
  assign mz = az >> IVL_MED_SHIFT;
  assign lx = ax >> IVL_LARGE_SHIFT;
  assign ly = ay >> IVL_LARGE_SHIFT;
  assign lz = az >> IVL_MED_SHIFT;

  always_comb begin
    if ((m & IVL_SMALL_MASK) == 32'd0) begin
      q_wdata.regime = REGIME_SMALL;
      q_wdata.op_x   = ax[IVL_OP_XY_W-1:0];
      q_wdata.op_y   = ay[IVL_OP_XY_W-1:0];
      q_wdata.op_z   = az[IVL_OP_Z_W-1:0];
    end else if ((m & IVL_MEDIUM_MASK) == 32'd0) begin
      q_wdata.regime = REGIME_MEDIUM;
      q_wdata.op_x   = mx[IVL_OP_XY_W-1:0];
      q_wdata.op_y   = my[IVL_OP_XY_W-1:0];
      q_wdata.op_z   = mz[IVL_OP_Z_W-1:0];
    end else begin
      q_wdata.regime = REGIME_LARGE;
      q_wdata.op_x   = lx[IVL_OP_XY_W-1:0];
      q_wdata.op_y   = ly[IVL_OP_XY_W-1:0];
      q_wdata.op_z   = lz[IVL_OP_Z_W-1:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

### rtl/ivl_queue.sv
module ivl_queue
  import ivl_pkg::*;
#(
  parameter int DEPTH = IVL_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ivl_entry_t wdata,
  input  logic       pop,
  output ivl_entry_t rdata,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ivl_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("word popped from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### rtl/ivl_back.sv
module ivl_back
  import ivl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  ivl_entry_t  q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_length
);

  localparam int NST = IVL_ROOT_W;

  logic        en;
  logic        v0_r, v1_r, v2_r;
  ivl_entry_t  ent0_r;
  logic [31:0] sqx_r, sqy_r, sqz_r, sum_r;
  regime_t     rg0_r, rg1_r;
  logic        sv_r  [1:NST];
  sq_acc_t     acc_r [1:NST];
  logic [31:0] val_r [1:NST];
  regime_t     rg_r  [1:NST];
  logic        out_valid_r;
  logic [31:0] out_length_r, length_nxt;

  logic [2*IVL_OP_XY_W-1:0] px, py;
  logic [2*IVL_OP_Z_W-1:0]  pz;

  assign en    = !(out_valid_r && out_stall);
  assign q_pop = en && !q_empty;

  assign px = {{IVL_OP_XY_W{1'b0}}, ent0_r.op_x} * {{IVL_OP_XY_W{1'b0}}, ent0_r.op_x};
  assign py = {{IVL_OP_XY_W{1'b0}}, ent0_r.op_y} * {{IVL_OP_XY_W{1'b0}}, ent0_r.op_y};
  assign pz = {{IVL_OP_Z_W{1'b0}}, ent0_r.op_z} * {{IVL_OP_Z_W{1'b0}}, ent0_r.op_z};

  always_comb begin
    case (rg_r[NST])
      REGIME_SMALL:  length_nxt = 32'(acc_r[NST].root);
      REGIME_MEDIUM: length_nxt = 32'(acc_r[NST].root) << IVL_MED_SHIFT;
      REGIME_LARGE:  length_nxt = 32'(acc_r[NST].root) << IVL_LARGE_SHIFT;
      default:       length_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 1; k <= NST; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r        <= q_pop;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      sv_r[1]     <= v2_r;
      for (int k = 1; k < NST; k++) begin
        sv_r[k+1] <= sv_r[k];
      end
      out_valid_r <= sv_r[NST];
    end
  end

  // entry, squares, wrapped sum, one root bit per stage, length scaled by regime
  always_ff @(posedge clk) begin
    if (en) begin
      ent0_r   <= q_rdata;
      sqx_r    <= 32'(px);
      sqy_r    <= 32'(py);
      sqz_r    <= pz[31:0];
      rg0_r    <= ent0_r.regime;
      sum_r    <= sqx_r + sqy_r + sqz_r;
      rg1_r    <= rg0_r;
      acc_r[1] <= sqrt_step('0, sum_r[31:30]);
      val_r[1] <= sum_r;
      rg_r[1]  <= rg1_r;
      for (int k = 1; k < NST; k++) begin
        acc_r[k+1] <= sqrt_step(acc_r[k], val_r[k][2*(NST-k)-1 -: 2]);
        val_r[k+1] <= val_r[k];
        rg_r[k+1]  <= rg_r[k];
      end
      out_length_r <= length_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_length = out_length_r;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ivl_pkg::*;

  localparam int PER_PHASE = 640;
  localparam int WD_LIMIT  = 1000;
  localparam int DRAIN_CYC = 40;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        chk;
    logic [31:0] len;
  } dir_row_t;

  localparam int DIR_N = 20;
  // chk set: length typed in, otherwise taken from the predictor
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0003, 32'h0000_0004, 32'h0000_000C, 1'b1, 32'h0000_000D},
    '{32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'hFFFF_FFF4, 1'b1, 32'h0000_000D},
    '{32'h0000_07FF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_07FF},
    '{32'h0000_0800, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0800},
    '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_F800, 1'b1, 32'h0000_0800},
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFC_0000},
    '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{32'h0000_07FF, 32'h0000_07FF, 32'h0000_07FF, 1'b0, 32'h0},
    '{32'hFFFF_F801, 32'h0000_07FF, 32'hFFFF_F801, 1'b0, 32'h0},
    '{32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 1'b0, 32'h0},
    '{32'h0020_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0020_0000, 32'h00FF_FFFF, 1'b0, 32'h0},
    '{32'h4000_0000, 32'h4000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1234_5678, 32'hF543_2110, 32'h0000_0ABC, 1'b0, 32'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_comp_x;
  logic [31:0] in_comp_y;
  logic [31:0] in_comp_z;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_length;

  logic [31:0] exp_len_q [$];
  int          snd_idle;
  int          rcv_idle;
  int          err_cnt;
  int          n_sent;
  int          n_checked;
  int          idle_cyc;
  logic [31:0] exp_len;

  int_vector3_length u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_comp_x  (in_comp_x),
    .in_comp_y  (in_comp_y),
    .in_comp_z  (in_comp_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_length (out_length)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] floor_root(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] sq;
    root = 32'h0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'h1 << b);
      sq    = 64'(trial) * 64'(trial);
      if (sq <= 64'(v)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] vec_length(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] ax, ay, az, m;
    logic [31:0] sx, sy, sz, sum;
    int          sh;
    ax = x[31] ? -x : x;
    ay = y[31] ? -y : y;
    az = z[31] ? -z : z;
    m  = ax | ay | az;
    if ((m & IVL_SMALL_MASK) == 32'h0) begin
      sx = ax;
      sy = ay;
      sz = az;
      sh = 0;
    end else if ((m & IVL_MEDIUM_MASK) == 32'h0) begin
      sx = ax >> IVL_MED_SHIFT;
      sy = ay >> IVL_MED_SHIFT;
      sz = az >> IVL_MED_SHIFT;
      sh = IVL_MED_SHIFT;
    end else begin
      // z keeps the medium shift in the large regime
      sx = ax >> IVL_LARGE_SHIFT;
      sy = ay >> IVL_LARGE_SHIFT;
      sz = az >> IVL_MED_SHIFT;
      sh = IVL_LARGE_SHIFT;
    end
    sum = sx * sx + sy * sy + sz * sz;
    return floor_root(sum) << sh;
  endfunction

  function automatic logic [31:0] rand_comp(int bits);
    logic [31:0] v;
    int          w;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h0000_07FF;
        3:       v = 32'hFFFF_F800;
        4:       v = 32'h001F_FFFF;
        5:       v = 32'h0020_0000;
        6:       v = 32'h7FFF_FFFF;
        7:       v = 32'h8000_0000;
        8:       v = 32'h00FF_FFFF;
        default: v = 32'h0100_0000;
      endcase
    end else begin
      v = $urandom;
      w = $urandom_range(1, bits);
      if (w < 32) v = v & ((32'h1 << w) - 32'h1);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input logic chk, input logic [31:0] len);
    logic done;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid  = 1'b0;
      in_comp_x = $urandom;
      in_comp_y = $urandom;
      in_comp_z = $urandom;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_comp_x = x;
    in_comp_y = y;
    in_comp_z = z;
    done      = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (!in_stall) begin
        done = 1'b1;
        exp_len_q.push_back(chk ? len : vec_length(x, y, z));
        n_sent++;
      end
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rcv_idle);
  end

  // compare each length word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_len_q.size() == 0) begin
        report_mismatch("unexpected length", out_length, 32'h0);
      end else begin
        exp_len = exp_len_q.pop_front();
        if (out_length !== exp_len) report_mismatch("length", out_length, exp_len);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WD_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    int bits;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_comp_x = 32'h0;
    in_comp_y = 32'h0;
    in_comp_z = 32'h0;
    out_stall = 1'b0;
    snd_idle  = 17;
    rcv_idle  = 85;
    err_cnt   = 0;
    n_sent    = 0;
    n_checked = 0;
    idle_cyc  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_vec(DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].z, DIR_TAB[i].chk, DIR_TAB[i].len);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle = 17;
          rcv_idle = 85;
        end
        1: begin
          snd_idle = 85;
          rcv_idle = 17;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      repeat (PER_PHASE) begin
        // pick a regime ceiling per vector
        case ($urandom_range(0, 2))
          0:       bits = 11;
          1:       bits = 21;
          default: bits = 32;
        endcase
        send_vec(rand_comp(bits), rand_comp(bits), rand_comp(bits), 1'b0, 32'h0);
      end
    end
    in_valid = 1'b0;

    while (exp_len_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("summary: %0d vectors sent (%0d from the table), %0d lengths checked",
             n_sent, DIR_N, n_checked);
    $display("summary: small, medium and large regimes over three idle mixes, %0d errors",
             err_cnt);
    if (err_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ivl_pkg.sv
rtl/ivl_front.sv
rtl/ivl_queue.sv
rtl/ivl_back.sv
rtl/int_vector3_length.sv
verif/testbench.sv
